>>> design/text_matrix_number_parser_unit_defines.svh
// Assertion macros shared by the text matrix number parser modules.
// Included by the files that check their own logic; no other dependencies.
`ifndef TEXT_MATRIX_NUMBER_PARSER_UNIT_DEFINES_SVH
`define TEXT_MATRIX_NUMBER_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TMNP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmnp assertion failed");
`define TMNP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmnp assertion failed");
`else
`define TMNP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TMNP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/tmnp_pkg.sv
// Types and constants of the text matrix number parser.
// No dependencies; imported by every module of the block.
package tmnp_pkg;

    localparam logic [2:0] MODE_TOP     = 3'd0;
    localparam logic [2:0] MODE_ZERO    = 3'd1;
    localparam logic [2:0] MODE_HEX     = 3'd2;
    localparam logic [2:0] MODE_DEC     = 3'd3;
    localparam logic [2:0] MODE_NEG     = 3'd4;
    localparam logic [2:0] MODE_COMMENT = 3'd5;

    localparam logic [1:0] PH_NONE  = 2'd0;
    localparam logic [1:0] PH_SLASH = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;
    localparam logic [1:0] PH_STAR  = 2'd3;

    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] CFG_NUM_COLUMNS  = 2'd0;
    localparam logic [1:0] CFG_NUM_ROWS     = 2'd1;
    localparam logic [1:0] CFG_MAX_ELEMENTS = 2'd2;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef struct packed {
        logic               kind;
        logic [12:0]        row_index;
        logic [12:0]        col_index;
        logic signed [63:0] value;
        logic [24:0]        element_count;
        logic               dropped;
    } result_t;

    typedef struct packed {
        logic [1:0] beats;
        result_t    beat0;
        result_t    beat1;
    } result_pair_t;

endpackage

>>> design/text_matrix_number_parser_unit.sv
// Top level of the text matrix number parser.
// Instantiates tmnp_parser and tmnp_result_fifo; depends on tmnp_pkg.

// The block takes one text byte per cycle, back to back, as long as the
// four-beat result queue has room for two more beats. A taken byte is parsed
// while it sits in the input register. Its results enter the queue when the
// parse step advances, and the first result beat is offered on the result channel
// from the queue. A byte gives at most two result beats (an
// element and the end summary). A byte that gives two also stops parsing, so
// while the result channel is not stalled the queue never fills and the input
// never stalls. Stalls on the result channel fill the queue, and a pending byte
// is stalled once three beats wait. The configuration registers are written
// through a plain write port and must not change while bytes are in flight.
module text_matrix_number_parser_unit
    import tmnp_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [24:0]        cfg_data,
    input  logic               char_valid,
    output logic               char_stall,
    input  logic [7:0]         char_byte,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               kind,
    output logic [12:0]        row_index,
    output logic [12:0]        col_index,
    output logic signed [63:0] value,
    output logic [24:0]        element_count,
    output logic               dropped
);

    result_pair_t push;
    result_t      head;
    logic         room;

    tmnp_parser #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_byte  (char_byte),
        .room       (room),
        .push       (push)
    );

    tmnp_result_fifo u_result_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .head         (head)
    );

    assign kind          = head.kind;
    assign row_index     = head.row_index;
    assign col_index     = head.col_index;
    assign value         = head.value;
    assign element_count = head.element_count;
    assign dropped       = head.dropped;

endmodule

>>> design/tmnp_result_fifo.sv
// Four-beat result queue between the parser and the output channel.
// Takes up to two beats per cycle and delivers one while the result channel is not stalled; depends on tmnp_pkg.
`include "text_matrix_number_parser_unit_defines.svh"

module tmnp_result_fifo
    import tmnp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  result_pair_t push,
    output logic         room,
    output logic         result_valid,
    input  logic         result_stall,
    output result_t      head
);

    result_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    wr_ptr_reg;
    logic [FIFO_AW-1:0]    rd_ptr_reg;
    logic [FIFO_AW:0]      count_reg;
    logic [FIFO_AW:0]      count_next;
    logic                  pop;

    assign result_valid = (count_reg != '0);
    assign pop          = result_valid && !result_stall;
    assign room         = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign head         = mem_reg[rd_ptr_reg];
    assign count_next   = count_reg + {{(FIFO_AW-1){1'b0}}, push.beats}
                          - {{FIFO_AW{1'b0}}, pop};

    always_ff @(posedge clk)
    begin
        if (push.beats != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.beat0;
        end
        if (push.beats == 2'd2)
        begin
            mem_reg[wr_ptr_reg + FIFO_AW'(1)] <= push.beat1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push.beats);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    `TMNP_ASSERT_IMP(a_no_overflow, clk, rst_n, 1'b1, count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
    `TMNP_ASSERT_IMP(a_push_has_room, clk, rst_n, push.beats != 2'd0, room && push.beats != 2'd3)
    `TMNP_ASSERT_NXT(a_pop_drains, clk, rst_n, pop && push.beats == 2'd0,
                     count_reg == $past(count_reg) - (FIFO_AW+1)'(1))

endmodule

>>> design/tmnp_parser.sv
// Byte input register, configuration registers and the per-byte parse step.
// Produces up to two result beats per byte; depends on tmnp_pkg.
`include "text_matrix_number_parser_unit_defines.svh"

module tmnp_parser
    import tmnp_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [24:0]  cfg_data,
    input  logic         char_valid,
    output logic         char_stall,
    input  logic [7:0]   char_byte,
    input  logic         room,
    output result_pair_t push
);

    logic [12:0] num_columns_reg;
    logic [12:0] num_rows_reg;
    logic [24:0] max_elements_reg;

    logic [7:0]  byte_reg;
    logic        byte_valid_reg;
    logic        advance;

    logic [2:0]  mode_reg,    mode_next;
    logic [2:0]  resume_reg,  resume_next;
    logic [1:0]  phase_reg,   phase_next;
    logic [63:0] acc_reg,     acc_next;
    logic [12:0] row_reg,     row_next;
    logic [12:0] col_reg,     col_next;
    logic [24:0] cnt_reg,     cnt_next;
    logic        drop_reg,    drop_next;
    logic        stopped_reg, stopped_next;

    result_pair_t pair;

    logic        enabled;
    logic        rows_ok;
    logic        cols_ok;
    logic        is_dec;
    logic        is_hex_lower;
    logic        is_hex_upper;
    logic        is_sep;
    logic        row_end;
    logic [3:0]  dec_digit;
    logic [3:0]  hex_digit;
    logic [63:0] acc_times_ten;
    logic [24:0] cnt_inc;

    assign advance    = byte_valid_reg && room;
    assign char_stall = byte_valid_reg && !room;

    assign enabled = (num_columns_reg != '0) && (num_rows_reg != '0)
                     && (max_elements_reg != '0);
    assign rows_ok = (row_reg < num_rows_reg) && ({19'd0, row_reg} < 32'(MAX_ROWS));
    assign cols_ok = (col_reg < num_columns_reg) && ({19'd0, col_reg} < 32'(MAX_COLUMNS));

    assign is_dec       = (byte_reg >= CH_ZERO) && (byte_reg <= CH_NINE);
    assign is_hex_lower = (byte_reg >= CH_LOWER_A) && (byte_reg <= CH_LOWER_F);
    assign is_hex_upper = (byte_reg >= CH_UPPER_A) && (byte_reg <= CH_UPPER_F);
    assign is_sep       = (byte_reg == CH_COMMA) || (byte_reg == CH_SEMI);
    assign row_end      = (byte_reg == CH_SEMI);
    assign dec_digit    = 4'(byte_reg - CH_ZERO);
    assign hex_digit    = is_dec       ? dec_digit :
                          is_hex_lower ? 4'(byte_reg - CH_LOWER_A + HEX_LETTER_BASE) :
                                         4'(byte_reg - CH_UPPER_A + HEX_LETTER_BASE);
    assign acc_times_ten = (acc_reg << 3) + (acc_reg << 1);
    assign cnt_inc       = cnt_reg + 25'd1;

    always_comb
    begin
        logic [2:0]  eff;
        logic        do_sep;
        logic        neg;
        logic        number_end;
        logic [63:0] sep_val;

        eff        = mode_reg;
        do_sep     = 1'b0;
        neg        = 1'b0;
        number_end = 1'b0;
        sep_val    = acc_reg;

        mode_next    = mode_reg;
        resume_next  = resume_reg;
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        cnt_next     = cnt_reg;
        drop_next    = drop_reg;
        stopped_next = stopped_reg;
        pair         = '0;

        if (byte_reg == CH_NUL)
        begin
            pair.beats      = (!enabled || !stopped_reg) ? 2'd1 : 2'd0;
            pair.beat0.kind = KIND_SUMMARY;
            if (enabled)
            begin
                pair.beat0.row_index     = row_reg;
                pair.beat0.col_index     = col_reg;
                pair.beat0.element_count = cnt_reg;
                pair.beat0.dropped       = drop_reg;
            end
            mode_next    = MODE_TOP;
            resume_next  = MODE_TOP;
            phase_next   = PH_NONE;
            acc_next     = '0;
            row_next     = '0;
            col_next     = '0;
            cnt_next     = '0;
            drop_next    = 1'b0;
            stopped_next = 1'b0;
        end
        else if (enabled && !stopped_reg)
        begin
            if (cnt_reg >= max_elements_reg)
            begin
                pair.beats                = 2'd1;
                pair.beat0.kind           = KIND_SUMMARY;
                pair.beat0.row_index      = row_reg;
                pair.beat0.col_index      = col_reg;
                pair.beat0.element_count  = cnt_reg;
                pair.beat0.dropped        = drop_reg;
                stopped_next              = 1'b1;
            end
            else
            begin
                // A pending zero or lone slash falls back and the byte is reparsed.
                if (mode_reg == MODE_ZERO && byte_reg != CH_X)
                begin
                    eff = MODE_TOP;
                end
                else if (mode_reg == MODE_COMMENT
                         && ((phase_reg == PH_SLASH && byte_reg != CH_STAR)
                             || phase_reg == PH_NONE))
                begin
                    eff        = (resume_reg > MODE_NEG) ? MODE_TOP : resume_reg;
                    phase_next = PH_NONE;
                end
                else if (mode_reg > MODE_COMMENT)
                begin
                    eff = MODE_TOP;
                end
                mode_next = eff;

                case (eff)
                    MODE_TOP:
                    begin
                        if (byte_reg == CH_SLASH)
                        begin
                            resume_next = eff;
                            mode_next   = MODE_COMMENT;
                            phase_next  = PH_SLASH;
                        end
                        else if (byte_reg == CH_ZERO)
                        begin
                            mode_next = MODE_ZERO;
                        end
                        else if (byte_reg == CH_MINUS)
                        begin
                            acc_next  = '0;
                            mode_next = MODE_NEG;
                        end
                        else if (is_dec)
                        begin
                            acc_next  = {60'd0, dec_digit};
                            mode_next = MODE_DEC;
                        end
                        else if (is_sep)
                        begin
                            do_sep = 1'b1;
                        end
                    end
                    MODE_ZERO:
                    begin
                        acc_next  = '0;
                        mode_next = MODE_HEX;
                    end
                    MODE_HEX:
                    begin
                        if (byte_reg == CH_SLASH)
                        begin
                            resume_next = eff;
                            mode_next   = MODE_COMMENT;
                            phase_next  = PH_SLASH;
                        end
                        else if (is_dec || is_hex_lower || is_hex_upper)
                        begin
                            acc_next = {acc_reg[59:0], hex_digit};
                        end
                        else if (is_sep)
                        begin
                            do_sep     = 1'b1;
                            number_end = 1'b1;
                        end
                    end
                    MODE_DEC, MODE_NEG:
                    begin
                        if (byte_reg == CH_SLASH)
                        begin
                            resume_next = eff;
                            mode_next   = MODE_COMMENT;
                            phase_next  = PH_SLASH;
                        end
                        else if (is_dec)
                        begin
                            acc_next = acc_times_ten + {60'd0, dec_digit};
                        end
                        else if (is_sep)
                        begin
                            do_sep     = 1'b1;
                            number_end = 1'b1;
                            neg        = (eff == MODE_NEG);
                        end
                    end
                    MODE_COMMENT:
                    begin
                        case (phase_reg)
                            PH_SLASH:
                            begin
                                phase_next = PH_BODY;
                            end
                            PH_BODY:
                            begin
                                if (byte_reg == CH_STAR)
                                begin
                                    phase_next = PH_STAR;
                                end
                            end
                            PH_STAR:
                            begin
                                if (byte_reg == CH_SLASH)
                                begin
                                    phase_next = PH_NONE;
                                    mode_next  = resume_reg;
                                end
                                else if (byte_reg != CH_STAR)
                                begin
                                    phase_next = PH_BODY;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_NONE;
                            end
                        endcase
                    end
                    default:
                    begin
                        mode_next = MODE_TOP;
                    end
                endcase

                if (do_sep)
                begin
                    sep_val = neg ? (64'd0 - acc_reg) : acc_reg;
                    if (number_end)
                    begin
                        mode_next = MODE_TOP;
                    end
                    if (!rows_ok || (!cols_ok && !row_end))
                    begin
                        // The value is dropped; a negative number stays negated.
                        drop_next = 1'b1;
                        acc_next  = sep_val;
                    end
                    else
                    begin
                        acc_next  = '0;
                        drop_next = drop_reg || !cols_ok;
                        if (row_end)
                        begin
                            row_next = row_reg + 13'd1;
                            col_next = '0;
                        end
                        else
                        begin
                            col_next = col_reg + 13'd1;
                        end
                        if (cols_ok)
                        begin
                            cnt_next                 = cnt_inc;
                            pair.beats               = 2'd1;
                            pair.beat0.kind          = KIND_ELEMENT;
                            pair.beat0.row_index     = row_reg;
                            pair.beat0.col_index     = col_reg;
                            pair.beat0.value         = sep_val;
                            pair.beat0.element_count = cnt_inc;
                            pair.beat0.dropped       = drop_reg;
                            if (cnt_inc >= max_elements_reg)
                            begin
                                pair.beats               = 2'd2;
                                pair.beat1.kind          = KIND_SUMMARY;
                                pair.beat1.row_index     = row_next;
                                pair.beat1.col_index     = col_next;
                                pair.beat1.element_count = cnt_inc;
                                pair.beat1.dropped       = drop_reg;
                                stopped_next             = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        push = pair;
        if (!advance)
        begin
            push.beats = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            byte_reg <= char_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_columns_reg  <= '0;
            num_rows_reg     <= '0;
            max_elements_reg <= '0;
            byte_valid_reg   <= 1'b0;
            mode_reg         <= MODE_TOP;
            resume_reg       <= MODE_TOP;
            phase_reg        <= PH_NONE;
            acc_reg          <= '0;
            row_reg          <= '0;
            col_reg          <= '0;
            cnt_reg          <= '0;
            drop_reg         <= 1'b0;
            stopped_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NUM_COLUMNS:  num_columns_reg  <= cfg_data[12:0];
                    CFG_NUM_ROWS:     num_rows_reg     <= cfg_data[12:0];
                    CFG_MAX_ELEMENTS: max_elements_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (char_valid && !char_stall)
            begin
                byte_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                byte_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                mode_reg    <= mode_next;
                resume_reg  <= resume_next;
                phase_reg   <= phase_next;
                acc_reg     <= acc_next;
                row_reg     <= row_next;
                col_reg     <= col_next;
                cnt_reg     <= cnt_next;
                drop_reg    <= drop_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    `TMNP_ASSERT_IMP(a_quiet_when_stopped, clk, rst_n,
                     advance && stopped_reg && byte_reg != CH_NUL, push.beats == 2'd0)
    `TMNP_ASSERT_IMP(a_pair_ends_in_summary, clk, rst_n,
                     push.beats == 2'd2, push.beat1.kind == KIND_SUMMARY && stopped_next)
    `TMNP_ASSERT_NXT(a_nul_rearms, clk, rst_n,
                     advance && byte_reg == CH_NUL,
                     cnt_reg == '0 && !stopped_reg && mode_reg == MODE_TOP)

endmodule
